[src/rcch_pkg.sv]
package rcch_pkg;

  localparam int ENTITY_ID_BITS = 16;
  localparam int POS_W = 24;
  localparam int DIR_W = 16;
  localparam int LEN_W = 24;
  localparam int SIZE_W = 20;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 24;

  // quotient bits kept by the divider; larger quotients saturate
  localparam int DIV_STEPS = 25;
  localparam int DIV_CNT_W = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_START_X = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_Z = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DIR_X = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DIR_Y = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DIR_Z = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CLAMP = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DIST = 3'd7;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_HSQ_A,
    OP_HSQ_B,
    OP_DOT_A,
    OP_DOT_B,
    OP_SNUM_A,
    OP_SNUM_B,
    OP_TLOAD,
    OP_DIV,
    OP_SLOAD,
    OP_OFFSET,
    OP_PX,
    OP_PY,
    OP_PZ,
    OP_DIFF,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_Z,
    OP_CMP,
    OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_HSQ_A,
    ST_HSQ_B,
    ST_DOT_A,
    ST_DOT_B,
    ST_SNUM_A,
    ST_SNUM_B,
    ST_TLOAD,
    ST_TDIV,
    ST_SLOAD,
    ST_SDIV,
    ST_OFFSET,
    ST_PX,
    ST_PY,
    ST_PZ,
    ST_DIFF,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_CMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_stall;
  } status_t;

endpackage

[src/rcch_datapath.sv]
module rcch_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [rcch_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [rcch_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic signed [rcch_pkg::POS_W-1:0]       center_x,
  input  logic signed [rcch_pkg::POS_W-1:0]       center_y,
  input  logic signed [rcch_pkg::POS_W-1:0]       center_z,
  input  logic [rcch_pkg::SIZE_W-1:0]             capsule_radius,
  input  logic [rcch_pkg::SIZE_W-1:0]             half_height,
  input  logic [rcch_pkg::ENTITY_ID_BITS-1:0]     entity_id,
  input  logic                                    last_candidate,
  input  rcch_pkg::cmd_t                          cmd,
  output rcch_pkg::status_t                       status,
  input  logic                                    out_ready,
  output logic                                    out_valid,
  output logic                                    hit_found,
  output logic signed [rcch_pkg::POS_W-1:0]       hit_x,
  output logic signed [rcch_pkg::POS_W-1:0]       hit_y,
  output logic signed [rcch_pkg::POS_W-1:0]       hit_z,
  output logic [rcch_pkg::ENTITY_ID_BITS-1:0]     hit_entity,
  output logic [rcch_pkg::LEN_W-1:0]              hit_distance
);

  // ray registers
  logic signed [23:0] sx, sy, sz;
  logic signed [15:0] ux, uy, uz;
  logic [23:0] clamp, maxd;

  // candidate
  logic signed [23:0] cx, cy, cz;
  logic [19:0] rad, hh;
  logic [rcch_pkg::ENTITY_ID_BITS-1:0] ent;
  logic last;

  logic signed [24:0] wx, wy;
  logic signed [25:0] wz;
  logic [30:0] acc_h;
  logic [31:0] hsq;
  logic signed [40:0] acc_d;
  logic signed [41:0] hdot;
  logic signed [59:0] acc_s, snum, tnum;

  // divider
  logic [24:0] div_low, div_q;
  logic [31:0] div_rem;
  logic div_ovf;

  logic [23:0] t;
  logic [20:0] off;
  logic signed [28:0] px, py, pz;
  logic signed [29:0] dx, dy, dz;
  logic [39:0] r2;
  logic [61:0] dist2;

  // query state
  logic [23:0] best_distance;
  logic found;
  logic signed [23:0] best_x, best_y, best_z;
  logic [rcch_pkg::ENTITY_ID_BITS-1:0] best_ent;

  // comb
  logic signed [59:0] load_num;
  logic [58:0] load_u;
  logic [33:0] load_hi;
  logic [32:0] rem2;
  logic [24:0] qsat;
  logic [23:0] t_sel;
  logic [20:0] two_hh, off_sel;
  logic signed [15:0] pu;
  logic signed [23:0] ps;
  logic signed [40:0] pprod;
  logic signed [41:0] prnd;
  logic signed [28:0] pnew;
  logic signed [25:0] az;
  logic signed [29:0] dsel;
  logic signed [59:0] sq;
  logic hit;

  always_comb begin
    load_num = (cmd.op == rcch_pkg::OP_TLOAD) ? tnum : snum;
    load_u = (load_num > 60'sd0) ? load_num[58:0] : 59'd0;
    load_hi = load_u[58:25];
    rem2 = {div_rem, div_low[24]};
    qsat = div_ovf ? {25{1'b1}} : div_q;
    t_sel = (qsat >= {1'b0, clamp}) ? clamp : qsat[23:0];
    two_hh = {hh, 1'b0};
    off_sel = (qsat >= {4'd0, two_hh}) ? two_hh : qsat[20:0];
    unique case (cmd.op)
      rcch_pkg::OP_PY: begin
        pu = uy;
        ps = sy;
        dsel = dy;
      end
      rcch_pkg::OP_PZ, rcch_pkg::OP_SQ_Z: begin
        pu = uz;
        ps = sz;
        dsel = dz;
      end
      default: begin
        pu = ux;
        ps = sx;
        dsel = (cmd.op == rcch_pkg::OP_SQ_Y) ? dy : dx;
      end
    endcase
    pprod = 41'(pu * $signed({1'b0, t}));
    prnd = 42'(pprod) + 42'sd8192;
    pnew = 29'(ps) + 29'($signed(prnd[41:14]));
    az = 26'(cz) - $signed({6'd0, hh}) + $signed({5'd0, off});
    sq = 60'(dsel * dsel);
    hit = (hh != 20'd0) && (hsq != 32'd0) && (dist2 <= {22'd0, r2}) &&
          (t < best_distance);
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rcch_pkg::OP_CAPTURE: begin
        cx <= center_x;
        cy <= center_y;
        cz <= center_z;
        rad <= capsule_radius;
        hh <= half_height;
        ent <= entity_id;
        last <= last_candidate;
        wx <= 25'(sx) - 25'(center_x);
        wy <= 25'(sy) - 25'(center_y);
        wz <= 26'(sz) - 26'(center_z) + $signed({6'd0, half_height});
      end
      rcch_pkg::OP_HSQ_A: acc_h <= 31'(ux * ux);
      rcch_pkg::OP_HSQ_B: hsq <= {1'b0, acc_h} + 32'(uy * uy);
      rcch_pkg::OP_DOT_A: acc_d <= 41'(ux * wx);
      rcch_pkg::OP_DOT_B: hdot <= 42'(acc_d) + 42'(uy * wy);
      rcch_pkg::OP_SNUM_A: begin
        acc_s <= 60'($signed({1'b0, hsq}) * wz);
        tnum <= -(60'(hdot) <<< 14);
      end
      rcch_pkg::OP_SNUM_B: snum <= acc_s - 60'(uz * hdot);
      rcch_pkg::OP_TLOAD, rcch_pkg::OP_SLOAD: begin
        div_low <= load_u[24:0];
        div_rem <= load_hi[31:0];
        div_ovf <= load_hi >= {2'd0, hsq};
        div_q <= '0;
        if (cmd.op == rcch_pkg::OP_SLOAD) begin
          t <= t_sel;
        end
      end
      rcch_pkg::OP_DIV: begin
        div_low <= {div_low[23:0], 1'b0};
        if (rem2 >= {1'b0, hsq}) begin
          div_rem <= 32'(rem2 - {1'b0, hsq});
          div_q <= {div_q[23:0], 1'b1};
        end else begin
          div_rem <= rem2[31:0];
          div_q <= {div_q[23:0], 1'b0};
        end
      end
      rcch_pkg::OP_OFFSET: off <= off_sel;
      rcch_pkg::OP_PX: px <= pnew;
      rcch_pkg::OP_PY: py <= pnew;
      rcch_pkg::OP_PZ: pz <= pnew;
      rcch_pkg::OP_DIFF: begin
        dx <= 30'(px) - 30'(cx);
        dy <= 30'(py) - 30'(cy);
        dz <= 30'(pz) - 30'(az);
        r2 <= rad * rad;
      end
      rcch_pkg::OP_SQ_X: dist2 <= 62'(sq);
      rcch_pkg::OP_SQ_Y, rcch_pkg::OP_SQ_Z: dist2 <= dist2 + 62'(sq);
      default: begin
      end
    endcase
  end

  function automatic logic signed [23:0] sat24(input logic signed [28:0] v);
    if (v > 29'sd8388607) begin
      return 24'sh7FFFFF;
    end
    if (v < -29'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= '0;
      sy <= '0;
      sz <= '0;
      ux <= 16'sd16384;
      uy <= '0;
      uz <= '0;
      clamp <= '0;
      maxd <= '0;
      best_distance <= '0;
      found <= 1'b0;
      best_x <= '0;
      best_y <= '0;
      best_z <= '0;
      best_ent <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rcch_pkg::REG_START_X: sx <= cfg_data;
          rcch_pkg::REG_START_Y: sy <= cfg_data;
          rcch_pkg::REG_START_Z: sz <= cfg_data;
          rcch_pkg::REG_DIR_X: ux <= cfg_data[15:0];
          rcch_pkg::REG_DIR_Y: uy <= cfg_data[15:0];
          rcch_pkg::REG_DIR_Z: uz <= cfg_data[15:0];
          rcch_pkg::REG_CLAMP: clamp <= cfg_data;
          rcch_pkg::REG_MAX_DIST: begin
            maxd <= cfg_data;
            best_distance <= cfg_data;
          end
        endcase
      end
      if (cmd.op == rcch_pkg::OP_CMP && hit) begin
        best_distance <= t;
        found <= 1'b1;
        best_x <= sat24(px);
        best_y <= sat24(py);
        best_z <= sat24(pz);
        best_ent <= ent;
      end
      if (cmd.op == rcch_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
        hit_found <= found;
        hit_x <= found ? best_x : '0;
        hit_y <= found ? best_y : '0;
        hit_z <= found ? best_z : '0;
        hit_entity <= found ? best_ent : '0;
        hit_distance <= found ? best_distance : '0;
        // start the next query
        best_distance <= maxd;
        found <= 1'b0;
        best_x <= '0;
        best_y <= '0;
        best_z <= '0;
        best_ent <= '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.last = last;
  assign status.out_stall = out_valid & ~out_ready;

  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit_found |-> hit_entity == '0 && hit_distance == '0)
    else $error("result without hit carries nonzero fields");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    cmd.op == rcch_pkg::OP_DIV && !div_ovf |-> div_rem < hsq)
    else $error("divider remainder out of range");

  a_t_clamped: assert property (@(posedge clk) disable iff (rst)
    cmd.op == rcch_pkg::OP_CMP |-> t <= clamp)
    else $error("ray parameter above clamp");

endmodule

[src/rcch_ctrl.sv]
module rcch_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rcch_pkg::status_t  status,
  output rcch_pkg::cmd_t     cmd
);

  rcch_pkg::state_t state, state_next;
  logic [rcch_pkg::DIV_CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcch_pkg::ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    in_ready = 1'b0;
    cmd.op = rcch_pkg::OP_NONE;
    unique case (state)
      rcch_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = rcch_pkg::OP_CAPTURE;
          state_next = rcch_pkg::ST_HSQ_A;
        end
      end
      rcch_pkg::ST_HSQ_A: begin
        cmd.op = rcch_pkg::OP_HSQ_A;
        state_next = rcch_pkg::ST_HSQ_B;
      end
      rcch_pkg::ST_HSQ_B: begin
        cmd.op = rcch_pkg::OP_HSQ_B;
        state_next = rcch_pkg::ST_DOT_A;
      end
      rcch_pkg::ST_DOT_A: begin
        cmd.op = rcch_pkg::OP_DOT_A;
        state_next = rcch_pkg::ST_DOT_B;
      end
      rcch_pkg::ST_DOT_B: begin
        cmd.op = rcch_pkg::OP_DOT_B;
        state_next = rcch_pkg::ST_SNUM_A;
      end
      rcch_pkg::ST_SNUM_A: begin
        cmd.op = rcch_pkg::OP_SNUM_A;
        state_next = rcch_pkg::ST_SNUM_B;
      end
      rcch_pkg::ST_SNUM_B: begin
        cmd.op = rcch_pkg::OP_SNUM_B;
        state_next = rcch_pkg::ST_TLOAD;
      end
      rcch_pkg::ST_TLOAD: begin
        cmd.op = rcch_pkg::OP_TLOAD;
        cnt_next = '0;
        state_next = rcch_pkg::ST_TDIV;
      end
      rcch_pkg::ST_TDIV: begin
        cmd.op = rcch_pkg::OP_DIV;
        cnt_next = cnt + 1'b1;
        if (cnt == rcch_pkg::DIV_CNT_W'(rcch_pkg::DIV_STEPS - 1)) begin
          state_next = rcch_pkg::ST_SLOAD;
        end
      end
      rcch_pkg::ST_SLOAD: begin
        cmd.op = rcch_pkg::OP_SLOAD;
        cnt_next = '0;
        state_next = rcch_pkg::ST_SDIV;
      end
      rcch_pkg::ST_SDIV: begin
        cmd.op = rcch_pkg::OP_DIV;
        cnt_next = cnt + 1'b1;
        if (cnt == rcch_pkg::DIV_CNT_W'(rcch_pkg::DIV_STEPS - 1)) begin
          state_next = rcch_pkg::ST_OFFSET;
        end
      end
      rcch_pkg::ST_OFFSET: begin
        cmd.op = rcch_pkg::OP_OFFSET;
        state_next = rcch_pkg::ST_PX;
      end
      rcch_pkg::ST_PX: begin
        cmd.op = rcch_pkg::OP_PX;
        state_next = rcch_pkg::ST_PY;
      end
      rcch_pkg::ST_PY: begin
        cmd.op = rcch_pkg::OP_PY;
        state_next = rcch_pkg::ST_PZ;
      end
      rcch_pkg::ST_PZ: begin
        cmd.op = rcch_pkg::OP_PZ;
        state_next = rcch_pkg::ST_DIFF;
      end
      rcch_pkg::ST_DIFF: begin
        cmd.op = rcch_pkg::OP_DIFF;
        state_next = rcch_pkg::ST_SQ_X;
      end
      rcch_pkg::ST_SQ_X: begin
        cmd.op = rcch_pkg::OP_SQ_X;
        state_next = rcch_pkg::ST_SQ_Y;
      end
      rcch_pkg::ST_SQ_Y: begin
        cmd.op = rcch_pkg::OP_SQ_Y;
        state_next = rcch_pkg::ST_SQ_Z;
      end
      rcch_pkg::ST_SQ_Z: begin
        cmd.op = rcch_pkg::OP_SQ_Z;
        state_next = rcch_pkg::ST_CMP;
      end
      rcch_pkg::ST_CMP: begin
        cmd.op = rcch_pkg::OP_CMP;
        state_next = status.last ? rcch_pkg::ST_EMIT : rcch_pkg::ST_IDLE;
      end
      rcch_pkg::ST_EMIT: begin
        // wait until the output register is free
        if (!status.out_stall) begin
          cmd.op = rcch_pkg::OP_EMIT;
          state_next = rcch_pkg::ST_IDLE;
        end
      end
      default: state_next = rcch_pkg::ST_IDLE;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second transaction while busy");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == rcch_pkg::ST_TDIV || state == rcch_pkg::ST_SDIV) |->
      cnt < rcch_pkg::DIV_CNT_W'(rcch_pkg::DIV_STEPS))
    else $error("divider step count overrun");

  a_emit_after_cmp: assert property (@(posedge clk) disable iff (rst)
    state == rcch_pkg::ST_EMIT |-> $past(state) == rcch_pkg::ST_CMP ||
      $past(state) == rcch_pkg::ST_EMIT)
    else $error("emit state entered out of sequence");

endmodule

[src/ray_capsule_closest_hit.sv]
// Closest hit of one configured ray against a stream of vertical capsules. Each capsule
// transaction is finished before the next one can be taken (the last candidate also has
// an emit step and any wait for the output register); most of it is two 25-step passes
// of the one shared restoring divider that computes the ray parameter and the axis
// offset, the rest are single multiply or add steps of the datapath. Only one capsule is
// in flight at a time. A result is produced only for the candidate marked last; it sits
// in an output register, so the next query can start while it waits.
module ray_capsule_closest_hit (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [rcch_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [rcch_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [rcch_pkg::POS_W-1:0]       center_x,
  input  logic signed [rcch_pkg::POS_W-1:0]       center_y,
  input  logic signed [rcch_pkg::POS_W-1:0]       center_z,
  input  logic [rcch_pkg::SIZE_W-1:0]             capsule_radius,
  input  logic [rcch_pkg::SIZE_W-1:0]             half_height,
  input  logic [rcch_pkg::ENTITY_ID_BITS-1:0]     entity_id,
  input  logic                                    last_candidate,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    hit_found,
  output logic signed [rcch_pkg::POS_W-1:0]       hit_x,
  output logic signed [rcch_pkg::POS_W-1:0]       hit_y,
  output logic signed [rcch_pkg::POS_W-1:0]       hit_z,
  output logic [rcch_pkg::ENTITY_ID_BITS-1:0]     hit_entity,
  output logic [rcch_pkg::LEN_W-1:0]              hit_distance
);

  rcch_pkg::cmd_t cmd;
  rcch_pkg::status_t status;

  rcch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rcch_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .center_x       (center_x),
    .center_y       (center_y),
    .center_z       (center_z),
    .capsule_radius (capsule_radius),
    .half_height    (half_height),
    .entity_id      (entity_id),
    .last_candidate (last_candidate),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .hit_found      (hit_found),
    .hit_x          (hit_x),
    .hit_y          (hit_y),
    .hit_z          (hit_z),
    .hit_entity     (hit_entity),
    .hit_distance   (hit_distance)
  );

endmodule

[dv/ray_capsule_closest_hit_checker.sv]
`timescale 1ns / 100ps

module ray_capsule_closest_hit_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rcch_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rcch_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [rcch_pkg::POS_W-1:0]   center_x,
  input  logic signed [rcch_pkg::POS_W-1:0]   center_y,
  input  logic signed [rcch_pkg::POS_W-1:0]   center_z,
  input  logic [rcch_pkg::SIZE_W-1:0]         capsule_radius,
  input  logic [rcch_pkg::SIZE_W-1:0]         half_height,
  input  logic [rcch_pkg::ENTITY_ID_BITS-1:0] entity_id,
  input  logic                                last_candidate,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                hit_found,
  input  logic signed [rcch_pkg::POS_W-1:0]   hit_x,
  input  logic signed [rcch_pkg::POS_W-1:0]   hit_y,
  input  logic signed [rcch_pkg::POS_W-1:0]   hit_z,
  input  logic [rcch_pkg::ENTITY_ID_BITS-1:0] hit_entity,
  input  logic [rcch_pkg::LEN_W-1:0]          hit_distance,
  output int                                  errors,
  output int                                  pending
);

  typedef struct {
    logic                                found;
    logic [rcch_pkg::POS_W-1:0]          x, y, z;
    logic [rcch_pkg::ENTITY_ID_BITS-1:0] ent;
    logic [rcch_pkg::LEN_W-1:0]          distance;
  } nearest_hit_t;

  nearest_hit_t hit_q[$];

  longint start_x, start_y, start_z, dir_x, dir_y, dir_z, clamp_len, max_dist;
  longint best_dist, best_x, best_y, best_z;
  logic   best_found;
  logic [rcch_pkg::ENTITY_ID_BITS-1:0] best_ent;

  function automatic longint clip24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  task automatic clear_query();
    best_dist = max_dist;
    best_found = 1'b0;
    best_x = 0;
    best_y = 0;
    best_z = 0;
    best_ent = '0;
  endtask

  task automatic trace_capsule();
    longint cx, cy, cz, rad, hh, bz, wx, wy, wz, hsq, hdot, tnum, snum;
    longint t, off, px, py, pz, dx, dy, dz, d2;
    cx = center_x;
    cy = center_y;
    cz = center_z;
    rad = {44'd0, capsule_radius};
    hh = {44'd0, half_height};
    hsq = dir_x * dir_x + dir_y * dir_y;
    if (hh == 0 || hsq == 0) return;
    bz = cz - hh;
    wx = start_x - cx;
    wy = start_y - cy;
    wz = start_z - bz;
    hdot = dir_x * wx + dir_y * wy;
    tnum = -hdot * 16384;
    t = (tnum > 0) ? tnum / hsq : 0;
    if (t > clamp_len) t = clamp_len;
    snum = hsq * wz - dir_z * hdot;
    off = (snum > 0) ? snum / hsq : 0;
    if (off > 2 * hh) off = 2 * hh;
    // round half up: arithmetic shift floors
    px = start_x + ((dir_x * t + 8192) >>> 14);
    py = start_y + ((dir_y * t + 8192) >>> 14);
    pz = start_z + ((dir_z * t + 8192) >>> 14);
    dx = px - cx;
    dy = py - cy;
    dz = pz - (bz + off);
    d2 = dx * dx + dy * dy + dz * dz;
    if (d2 <= rad * rad && t < best_dist) begin
      best_dist = t;
      best_x = clip24(px);
      best_y = clip24(py);
      best_z = clip24(pz);
      best_ent = entity_id;
      best_found = 1'b1;
    end
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    nearest_hit_t e;
    if (rst) begin
      start_x = 0; start_y = 0; start_z = 0;
      dir_x = 16384; dir_y = 0; dir_z = 0;
      clamp_len = 0;
      max_dist = 0;
      clear_query();
      hit_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rcch_pkg::REG_START_X:  start_x = $signed(cfg_data);
          rcch_pkg::REG_START_Y:  start_y = $signed(cfg_data);
          rcch_pkg::REG_START_Z:  start_z = $signed(cfg_data);
          rcch_pkg::REG_DIR_X:    dir_x = $signed(cfg_data[rcch_pkg::DIR_W-1:0]);
          rcch_pkg::REG_DIR_Y:    dir_y = $signed(cfg_data[rcch_pkg::DIR_W-1:0]);
          rcch_pkg::REG_DIR_Z:    dir_z = $signed(cfg_data[rcch_pkg::DIR_W-1:0]);
          rcch_pkg::REG_CLAMP:    clamp_len = {40'd0, cfg_data};
          rcch_pkg::REG_MAX_DIST: begin
            max_dist = {40'd0, cfg_data};
            best_dist = max_dist;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        trace_capsule();
        if (last_candidate) begin
          e.found = best_found;
          e.x = best_found ? best_x[rcch_pkg::POS_W-1:0] : '0;
          e.y = best_found ? best_y[rcch_pkg::POS_W-1:0] : '0;
          e.z = best_found ? best_z[rcch_pkg::POS_W-1:0] : '0;
          e.ent = best_found ? best_ent : '0;
          e.distance = best_found ? best_dist[rcch_pkg::LEN_W-1:0] : '0;
          hit_q.push_back(e);
          clear_query();
        end
      end
      if (out_valid && out_ready) begin
        if (hit_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result transaction: found %0b entity %0h", $time,
                   hit_found, hit_entity);
        end else begin
          e = hit_q.pop_front();
          check_field("hit_found", e.found, hit_found);
          check_field("hit_x", e.x, hit_x[rcch_pkg::POS_W-1:0]);
          check_field("hit_y", e.y, hit_y[rcch_pkg::POS_W-1:0]);
          check_field("hit_z", e.z, hit_z[rcch_pkg::POS_W-1:0]);
          check_field("hit_entity", e.ent, hit_entity);
          check_field("hit_distance", e.distance, hit_distance);
        end
      end
    end
    pending = hit_q.size();
  end

endmodule

[dv/ray_capsule_closest_hit_tb.sv]
`timescale 1ns / 100ps

module ray_capsule_closest_hit_tb;

  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rcch_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rcch_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [rcch_pkg::POS_W-1:0] center_x = '0, center_y = '0, center_z = '0;
  logic [rcch_pkg::SIZE_W-1:0] capsule_radius = '0, half_height = '0;
  logic [rcch_pkg::ENTITY_ID_BITS-1:0] entity_id = '0;
  logic last_candidate = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit_found;
  logic signed [rcch_pkg::POS_W-1:0] hit_x, hit_y, hit_z;
  logic [rcch_pkg::ENTITY_ID_BITS-1:0] hit_entity;
  logic [rcch_pkg::LEN_W-1:0] hit_distance;
  int errors, pending;
  int cycles = 0;
  int ready_cnt = 0;
  bit no_gaps = 0;

  // ray currently loaded, used to place capsules near it
  longint ray_sx, ray_sy, ray_sz, ray_dx, ray_dy, ray_dz, ray_clamp;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ray_capsule_closest_hit u_dut (.*);
  ray_capsule_closest_hit_checker u_checker (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver backpressure: bursts of ready and stalls, mostly short
  always @(posedge clk) begin
    if (ready_cnt == 0) begin
      if (out_ready) begin
        out_ready <= 1'b0;
        ready_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 4);
      end else begin
        out_ready <= 1'b1;
        ready_cnt <= $urandom_range(1, 80);
      end
    end else begin
      ready_cnt <= ready_cnt - 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic longint clip24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  task automatic push_capsule(longint cx, longint cy, longint cz, int rad, int hh,
                              int ent, bit last);
    int gap;
    gap = pick_gap();
    in_valid <= 1'b1;
    center_x <= cx[rcch_pkg::POS_W-1:0];
    center_y <= cy[rcch_pkg::POS_W-1:0];
    center_z <= cz[rcch_pkg::POS_W-1:0];
    capsule_radius <= rad[rcch_pkg::SIZE_W-1:0];
    half_height <= hh[rcch_pkg::SIZE_W-1:0];
    entity_id <= ent[rcch_pkg::ENTITY_ID_BITS-1:0];
    last_candidate <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // the caller drops the write enable after its last write
  task automatic write_reg(logic [rcch_pkg::CFG_INDEX_W-1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[rcch_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // let outstanding results drain and the datapath go idle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic load_ray(longint sx, longint sy, longint sz, longint dx, longint dy,
                          longint dz, longint clamp, longint maxd);
    drain();
    write_reg(rcch_pkg::REG_START_X, sx);
    write_reg(rcch_pkg::REG_START_Y, sy);
    write_reg(rcch_pkg::REG_START_Z, sz);
    write_reg(rcch_pkg::REG_DIR_X, dx);
    write_reg(rcch_pkg::REG_DIR_Y, dy);
    write_reg(rcch_pkg::REG_DIR_Z, dz);
    write_reg(rcch_pkg::REG_CLAMP, clamp);
    write_reg(rcch_pkg::REG_MAX_DIST, maxd);
    cfg_we <= 1'b0;
    ray_sx = sx; ray_sy = sy; ray_sz = sz;
    ray_dx = dx; ray_dy = dy; ray_dz = dz;
    ray_clamp = clamp;
  endtask

  function automatic longint rand_full24();
    return longint'($urandom_range(0, 24'hFFFFFF)) - 64'sd8388608;
  endfunction

  function automatic longint rand_dir();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16384;
    if (r == 1) return -16384;
    return longint'($urandom_range(0, 32768)) - 16384;
  endfunction

  // capsule placed on or near the ray, so hits are common
  task automatic push_near(bit last);
    longint tt, nx, ny, nz;
    int rad, hh;
    tt = $urandom_range(0, (ray_clamp > 6000) ? 6000 : int'(ray_clamp));
    nx = ray_sx + ((ray_dx * tt) >>> 14) + longint'($urandom_range(0, 400)) - 200;
    ny = ray_sy + ((ray_dy * tt) >>> 14) + longint'($urandom_range(0, 400)) - 200;
    nz = ray_sz + ((ray_dz * tt) >>> 14) + longint'($urandom_range(0, 400)) - 200;
    rad = $urandom_range(0, 300);
    hh = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 400);
    push_capsule(clip24(nx), clip24(ny), clip24(nz), rad, hh, $urandom_range(0, 65535), last);
  endtask

  task automatic push_noise(bit last);
    push_capsule(rand_full24(), rand_full24(), rand_full24(), $urandom_range(0, 20'hFFFFF),
                 $urandom_range(0, 20'hFFFFF), $urandom_range(0, 65535), last);
  endtask

  initial begin
    int qlen;
    ray_sx = 0; ray_sy = 0; ray_sz = 0;
    ray_dx = 16384; ray_dy = 0; ray_dz = 0; ray_clamp = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset ray: zero bound, nothing can hit
    push_capsule(0, 0, 0, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1);
    push_capsule(-64'sd8388608, 64'sd8388607, -64'sd8388608, 0, 1, 0, 1'b1);

    load_ray(0, 0, 0, 16384, 0, 0, 24'hFFFFFF, 24'hFFFFFF);
    push_capsule(1600, 0, 0, 16, 16, 16'h0001, 1'b0);
    push_capsule(800, 0, 0, 32, 16, 16'hFFFF, 1'b0);
    push_capsule(800, 0, 0, 32, 16, 16'h0000, 1'b0);   // tie keeps earlier entity
    push_capsule(400, 0, 0, 64, 0, 16'h1234, 1'b0);    // zero half height skipped
    push_capsule(3200, 0, 0, 0, 16, 16'h00AA, 1'b1);
    push_capsule(300, 10, 0, 20, 20, 16'hAAAA, 1'b1);  // hit on the last item alone
    push_capsule(64'sd8388607, 64'sd8388607, 64'sd8388607, 20'hFFFFF, 20'hFFFFF,
                 16'h5555, 1'b0);
    push_capsule(-64'sd8388608, -64'sd8388608, -64'sd8388608, 20'hFFFFF, 20'hFFFFF,
                 16'h8000, 1'b1);

    // vertical ray: zero denominator, every capsule skipped
    load_ray(0, 0, 0, 0, 0, 16384, 24'hFFFFFF, 24'hFFFFFF);
    push_capsule(0, 0, 0, 20'hFFFFF, 100, 16'h0007, 1'b0);
    push_capsule(0, 0, 100, 20'hFFFFF, 100, 16'h0008, 1'b1);

    // ray from the corner heading further out: saturated hit point
    load_ray(-64'sd8388608, 64'sd8388607, -64'sd8388608, -16384, 16384, -16384,
             24'hFFFFFF, 24'hFFFFFF);
    push_capsule(-64'sd8388608, 64'sd8388607, -64'sd8388000, 20'hFFFFF, 20'hFFFFF,
                 16'h0F0F, 1'b1);
    push_capsule(-64'sd8388600, 64'sd8388600, -64'sd8388608, 20'hFFFFF, 1, 16'hF0F0, 1'b1);

    // opposite corner, clamp at zero and small bound
    load_ray(64'sd8388607, -64'sd8388608, 64'sd8388607, 16384, -16384, 16384, 0, 1);
    push_capsule(64'sd8388607, -64'sd8388608, 64'sd8388607, 50, 50, 16'h0102, 1'b1);
    push_capsule(64'sd8388000, -64'sd8388000, 64'sd8388000, 20'hFFFFF, 20'hFFFFF,
                 16'h0304, 1'b1);

    for (int phase = 0; phase < 7; phase++) begin
      longint sx, sy, sz, clamp, maxd;
      int r;
      r = $urandom_range(0, 4);
      sx = (r == 0) ? rand_full24() : longint'($urandom_range(0, 60000)) - 30000;
      sy = (r == 0) ? rand_full24() : longint'($urandom_range(0, 60000)) - 30000;
      sz = (r == 0) ? rand_full24() : longint'($urandom_range(0, 60000)) - 30000;
      r = $urandom_range(0, 3);
      clamp = (r == 0) ? 24'hFFFFFF : (r == 1) ? 0 : $urandom_range(0, 20000);
      r = $urandom_range(0, 3);
      maxd = (r == 0) ? 24'hFFFFFF : (r == 1) ? $urandom_range(0, 100)
                                              : $urandom_range(0, 50000);
      load_ray(sx, sy, sz, rand_dir(), rand_dir(), rand_dir(), clamp, maxd);
      for (int n = 0; n < 75; n += qlen) begin
        qlen = $urandom_range(1, 8);
        no_gaps = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < qlen; k++) begin
          if ($urandom_range(0, 99) < 85) push_near(k == qlen - 1);
          else push_noise(k == qlen - 1);
        end
      end
      no_gaps = 0;
    end

    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
